[design/clc_pkg.sv]
// Shared types and codes for the callback slot lifecycle block.
// No dependencies; every design file imports this package.
package clc_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int ID_BITS     = 64;
    localparam int DETAIL_BITS = 64;

    // Operation codes
    localparam logic [2:0] OP_REGISTER   = 3'd0;
    localparam logic [2:0] OP_ENTER      = 3'd1;
    localparam logic [2:0] OP_LEAVE      = 3'd2;
    localparam logic [2:0] OP_BEGIN_UNREG  = 3'd3;
    localparam logic [2:0] OP_FINISH_UNREG = 3'd4;
    localparam logic [2:0] OP_UNREGISTER = 3'd5;

    // Slot states
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_ACTIVE  = 2'd1;
    localparam logic [1:0] ST_CLOSING = 2'd2;

    // Status codes
    localparam logic [2:0] S_NONE     = 3'd0;
    localparam logic [2:0] S_INVALID  = 3'd1;
    localparam logic [2:0] S_INFLIGHT = 3'd2;
    localparam logic [2:0] S_CLOSING  = 3'd3;
    localparam logic [2:0] S_ACTIVE   = 3'd4;
    localparam logic [2:0] S_REJECTED = 3'd5;
    localparam logic [2:0] S_NOTREG   = 3'd6;

    // Phases
    localparam logic [1:0] PH_VALIDATE = 2'd0;
    localparam logic [1:0] PH_INVOKE   = 2'd1;
    localparam logic [1:0] PH_CLEANUP  = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [2:0]         operation;
        logic [ID_BITS-1:0] callback_id;
        logic [ID_BITS-1:0] generation;
    } clc_req_t;

    typedef struct packed {
        logic                   ok;
        logic [2:0]             status;
        logic [1:0]             phase;
        logic [DETAIL_BITS-1:0] detail_expected;
        logic [DETAIL_BITS-1:0] detail_actual;
    } clc_rsp_t;

    typedef struct packed {
        logic [1:0]            slot_state;
        logic [COUNT_BITS-1:0] active_count;
        logic [ID_BITS-1:0]    stored_id;
        logic [ID_BITS-1:0]    stored_generation;
    } clc_slot_t;

    function automatic logic [DETAIL_BITS-1:0] count_detail(input logic [COUNT_BITS-1:0] c);
        count_detail = {{(DETAIL_BITS-COUNT_BITS){1'b0}}, c};
    endfunction

endpackage

[design/callback_slot_lifecycle.sv]
// Top level of the callback slot lifecycle block: input, slot and result registers.
// Depends on clc_pkg and clc_eval.
//
// One request is taken per clock cycle while in_stall is low. A request is
// captured in the input register, evaluated against the slot by clc_eval, and
// its result is captured in the result register. The slot is updated on the
// same edge that captures the result, so each request sees every earlier one.
// A stalled result holds; the input register then holds one more request
// before in_stall rises. Writing the malformed flag (cfg_wr_en, cfg_wr_data)
// takes effect on the next request evaluated.
module callback_slot_lifecycle (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  clc_pkg::clc_req_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output clc_pkg::clc_rsp_t out_data,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data
);
    import clc_pkg::*;

    logic      malformed_reg;
    logic      in_valid_reg;
    clc_req_t  req_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    clc_rsp_t  rsp_reg;
    clc_rsp_t  rsp_next;
    clc_slot_t slot_reg;
    clc_slot_t slot_next;
    logic      advance;
    logic      in_load;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_load  = !in_valid_reg || advance;
    assign in_stall = !in_load;

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    clc_eval u_eval (
        .malformed (malformed_reg),
        .req       (req_reg),
        .slot      (slot_reg),
        .rsp       (rsp_next),
        .slot_next (slot_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            malformed_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                malformed_reg <= cfg_wr_data;
            end
            if (in_load)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                slot_reg <= slot_next;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            req_reg <= in_data;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    // A free slot is always fully cleared
    a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg.slot_state == ST_FREE |->
            (slot_reg.active_count == '0 && slot_reg.stored_id == '0 &&
             slot_reg.stored_generation == '0))
        else $error("free slot holds stale contents");

    // An owned slot never carries the invalid id
    a_owned_id: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg.slot_state != ST_FREE |-> slot_reg.stored_id != '0)
        else $error("owned slot has zero id");

    // The unused state code is never reached
    a_no_state3: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg.slot_state == ST_FREE || slot_reg.slot_state == ST_ACTIVE ||
        slot_reg.slot_state == ST_CLOSING)
        else $error("slot entered unused state");

    // The call count moves by at most one per request
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg.active_count != $past(slot_reg.active_count) |->
            ($past(slot_reg.active_count) + COUNT_BITS'(1) == slot_reg.active_count ||
             $past(slot_reg.active_count) == slot_reg.active_count + COUNT_BITS'(1)))
        else $error("call count jumped");

    // A successful result never carries a failure status
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rsp_reg.ok |->
            (rsp_reg.status == S_NONE && rsp_reg.detail_expected == '0 &&
             rsp_reg.detail_actual == '0))
        else $error("ok result with failure detail");

endmodule

[design/clc_eval.sv]
// Request evaluation: result and next slot contents for one request.
// Depends on clc_pkg.
module clc_eval (
    input  logic               malformed,
    input  clc_pkg::clc_req_t  req,
    input  clc_pkg::clc_slot_t slot,
    output clc_pkg::clc_rsp_t  rsp,
    output clc_pkg::clc_slot_t slot_next
);
    import clc_pkg::*;

    logic bad;
    logic id_match;
    logic count_zero;

    assign bad        = malformed || (req.callback_id == '0);
    assign id_match   = (slot.stored_id == req.callback_id);
    assign count_zero = (slot.active_count == '0);

    always_comb
    begin
        slot_next = slot;
        rsp       = '0;
        unique case (req.operation) inside
            OP_REGISTER:
            begin
                rsp.phase = PH_VALIDATE;
                if (bad)
                begin
                    rsp.status        = S_INVALID;
                    rsp.detail_actual = req.callback_id;
                end
                else if (slot.slot_state == ST_FREE && (!count_zero ||
                         slot.stored_id != '0 || slot.stored_generation != '0))
                begin
                    rsp.status        = S_INVALID;
                    rsp.detail_actual = DETAIL_BITS'(1);
                end
                else if (slot.slot_state != ST_FREE)
                begin
                    rsp.status        = (slot.slot_state == ST_CLOSING) ? S_CLOSING : S_ACTIVE;
                    rsp.detail_actual = {{(DETAIL_BITS-2){1'b0}}, slot.slot_state};
                end
                else
                begin
                    rsp.ok                      = 1'b1;
                    slot_next.active_count      = '0;
                    slot_next.stored_id         = req.callback_id;
                    slot_next.stored_generation = req.generation;
                    slot_next.slot_state        = ST_ACTIVE;
                end
            end
            OP_ENTER:
            begin
                rsp.phase = PH_INVOKE;
                if (bad)
                begin
                    rsp.status          = S_INVALID;
                    rsp.detail_expected = req.callback_id;
                end
                else if (slot.slot_state != ST_ACTIVE || !id_match)
                begin
                    rsp.status          = S_REJECTED;
                    rsp.detail_expected = req.callback_id;
                    rsp.detail_actual   = slot.stored_id;
                end
                else if (slot.active_count == COUNT_MAX)
                begin
                    rsp.status          = S_REJECTED;
                    rsp.detail_expected = count_detail(COUNT_MAX);
                    rsp.detail_actual   = count_detail(COUNT_MAX);
                end
                else
                begin
                    rsp.ok                 = 1'b1;
                    slot_next.active_count = slot.active_count + COUNT_BITS'(1);
                end
            end
            OP_LEAVE:
            begin
                rsp.ok    = 1'b1;
                rsp.phase = PH_INVOKE;
                if (!malformed && !count_zero)
                begin
                    slot_next.active_count = slot.active_count - COUNT_BITS'(1);
                end
            end
            OP_BEGIN_UNREG, OP_UNREGISTER:
            begin
                rsp.phase = PH_CLEANUP;
                if (bad)
                begin
                    rsp.status          = S_INVALID;
                    rsp.detail_expected = req.callback_id;
                end
                else if (slot.slot_state != ST_ACTIVE || !id_match)
                begin
                    rsp.status          = (slot.slot_state == ST_CLOSING) ? S_CLOSING : S_NOTREG;
                    rsp.detail_expected = req.callback_id;
                    rsp.detail_actual   = slot.stored_id;
                end
                else if (req.operation == OP_BEGIN_UNREG)
                begin
                    rsp.ok               = 1'b1;
                    slot_next.slot_state = ST_CLOSING;
                end
                else if (count_zero)
                begin
                    // Combined form with no calls in flight retires straight to free, skipping closing
                    rsp.ok                      = 1'b1;
                    slot_next.slot_state        = ST_FREE;
                    slot_next.stored_id         = '0;
                    slot_next.stored_generation = '0;
                end
                else
                begin
                    rsp.status           = S_INFLIGHT;
                    rsp.detail_actual    = count_detail(slot.active_count);
                    slot_next.slot_state = ST_CLOSING;
                end
            end
            OP_FINISH_UNREG:
            begin
                rsp.phase = PH_CLEANUP;
                if (bad)
                begin
                    rsp.status          = S_INVALID;
                    rsp.detail_expected = req.callback_id;
                end
                else if (slot.slot_state != ST_CLOSING || !id_match)
                begin
                    rsp.status          = S_NOTREG;
                    rsp.detail_expected = req.callback_id;
                    rsp.detail_actual   = slot.stored_id;
                end
                else if (!count_zero)
                begin
                    rsp.status        = S_INFLIGHT;
                    rsp.detail_actual = count_detail(slot.active_count);
                end
                else
                begin
                    rsp.ok                      = 1'b1;
                    slot_next.slot_state        = ST_FREE;
                    slot_next.stored_id         = '0;
                    slot_next.stored_generation = '0;
                end
            end
            default:
            begin
                rsp.status = S_INVALID;
                rsp.phase  = PH_VALIDATE;
            end
        endcase
    end

endmodule
